>>> sv/saanh_pkg.sv
// Shared types and constants of the segment versus box nearest-hit block.
`default_nettype none
package saanh_pkg;

    localparam int T_FRAC_BITS = 16;
    localparam int TAG_BITS    = 16;

    localparam int COORD_W = 32;
    localparam int NUM_W   = COORD_W + 1;
    localparam int QMAG_W  = T_FRAC_BITS + 2;
    localparam int Q_W     = QMAG_W + 1;
    localparam int NT_W    = T_FRAC_BITS + 2;
    localparam int CNT_W   = $clog2(QMAG_W + 1);

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = 1;
    localparam int QCNT_W  = 2;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MASK    = 3'd4;

    localparam logic [QMAG_W-1:0] SAT_MAG = QMAG_W'(2) << T_FRAC_BITS;
    localparam logic signed [Q_W-1:0] T_ONE_Q = Q_W'(1) << T_FRAC_BITS;
    localparam logic [NT_W-1:0] T_SAT_NT = NT_W'(2) << T_FRAC_BITS;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic [COORD_W-1:0]        mask;
    } cfg_t;

    typedef struct packed {
        logic                      skip;
        logic                      last;
        logic [TAG_BITS-1:0]       tag;
        logic signed [NUM_W-1:0]   nlx;
        logic signed [NUM_W-1:0]   nhx;
        logic signed [NUM_W-1:0]   nly;
        logic signed [NUM_W-1:0]   nhy;
    } q_entry_t;

endpackage
`default_nettype wire

>>> sv/saanh_if.sv
// Request channel interfaces for boxes in and hit results out.
`default_nettype none
interface box_if;
    logic        valid;
    logic        ready;
    logic        box_active;
    logic [31:0] box_layer;
    logic signed [31:0] box_left;
    logic signed [31:0] box_right;
    logic signed [31:0] box_top;
    logic signed [31:0] box_bottom;
    logic [15:0] box_tag;
    logic        last_box;

    modport source (output valid, box_active, box_layer, box_left, box_right, box_top,
                    box_bottom, box_tag, last_box, input ready);
    modport sink (input valid, box_active, box_layer, box_left, box_right, box_top,
                  box_bottom, box_tag, last_box, output ready);
endinterface

interface hit_if;
    logic        valid;
    logic        ready;
    logic        hit_found;
    logic [15:0] hit_tag;
    logic [16:0] hit_t;
    logic signed [31:0] hit_point_x;
    logic signed [31:0] hit_point_y;

    modport source (output valid, hit_found, hit_tag, hit_t, hit_point_x, hit_point_y,
                    input ready);
    modport sink (input valid, hit_found, hit_tag, hit_t, hit_point_x, hit_point_y,
                  output ready);
endinterface
`default_nettype wire

>>> sv/saanh_front.sv
// Front end: accepts boxes, classifies them and queues the slab numerators.
`default_nettype none
module saanh_front
    import saanh_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    box_if.sink       box,
    output q_entry_t  head,
    output logic      head_valid,
    input  wire logic pop
);

    q_entry_t mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic push;
    q_entry_t ent;

    assign box.ready  = count_reg < QCNT_W'(QDEPTH);
    assign push       = box.valid && box.ready;
    assign head       = mem_reg[rd_ptr_reg];
    assign head_valid = count_reg != '0;

    always_comb
    begin
        ent.skip = !box.box_active || ((box.box_layer & cfg.mask) == '0);
        ent.last = box.last_box;
        ent.tag  = TAG_BITS'(box.box_tag);
        // Numerators are bound minus start, exact in one extra bit.
        ent.nlx = {box.box_left[31], box.box_left} - {cfg.start_x[31], cfg.start_x};
        ent.nhx = {box.box_right[31], box.box_right} - {cfg.start_x[31], cfg.start_x};
        ent.nly = {box.box_top[31], box.box_top} - {cfg.start_y[31], cfg.start_y};
        ent.nhy = {box.box_bottom[31], box.box_bottom} - {cfg.start_y[31], cfg.start_y};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= ent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= QCNT_W'(QDEPTH))
        else $error("box queue overfilled");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
        else $error("pop from empty box queue");

endmodule
`default_nettype wire

>>> sv/saanh_div.sv
// Restoring divider giving one slab time per run, one quotient bit per cycle.
`default_nettype none
module saanh_div
    import saanh_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic signed [NUM_W-1:0] num,
    input  wire logic signed [NUM_W-1:0] den,
    output logic                       done,
    output logic signed [Q_W-1:0]      quot
);

    logic              busy_reg, done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [NUM_W-1:0]  rem_reg, dmag_reg;
    logic [QMAG_W-1:0] low_reg, qb_reg;
    logic              sat_reg, neg_reg;
    logic signed [Q_W-1:0] quot_reg;

    logic [NUM_W-1:0]  mag_n, mag_d, rem_next;
    logic [NUM_W:0]    trial;
    logic              ge;
    logic [QMAG_W-1:0] qb_next, mag;
    logic signed [Q_W-1:0] q_fin;

    always_comb
    begin
        mag_n = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        mag_d = den[NUM_W-1] ? NUM_W'(-den) : NUM_W'(den);
        trial = {rem_reg, low_reg[QMAG_W-1]};
        ge = trial >= {1'b0, dmag_reg};
        rem_next = ge ? NUM_W'(trial - {1'b0, dmag_reg}) : NUM_W'(trial);
        qb_next = {qb_reg[QMAG_W-2:0], ge};
        // Quotients beyond two saturate; truncation acts on the magnitude.
        mag = (sat_reg || qb_next > SAT_MAG) ? SAT_MAG : qb_next;
        q_fin = neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= NUM_W'(mag_n >> 2);
            low_reg  <= {mag_n[1:0], {T_FRAC_BITS{1'b0}}};
            dmag_reg <= mag_d;
            qb_reg   <= '0;
            sat_reg  <= {2'b00, mag_n} >= {mag_d, 2'b00};
            neg_reg  <= num[NUM_W-1] ^ den[NUM_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            low_reg <= low_reg << 1;
            qb_reg  <= qb_next;
            if (cnt_reg == CNT_W'(1))
            begin
                quot_reg <= q_fin;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QMAG_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

    assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_reg)
        else $error("divider restarted while busy");
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg)
        else $error("divider done while still busy");

endmodule
`default_nettype wire

>>> sv/saanh_back.sv
// Back end: slab tests, nearest-hit tracking and the result register.
`default_nettype none
module saanh_back
    import saanh_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cfg_t     cfg,
    input  wire q_entry_t head,
    input  wire logic     head_valid,
    output logic          pop,
    hit_if.source         hit
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_MUL   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    localparam int P_W = NUM_W + NT_W + 1;
    localparam logic signed [P_W:0] PT_MAX = (P_W+1)'(64'sh7fffffff);
    localparam logic signed [P_W:0] PT_MIN = ~PT_MAX;

    logic [2:0] state_reg, state_next;
    logic [1:0] k_reg;
    q_entry_t   ent_reg;
    logic signed [Q_W-1:0] q_reg [4];
    logic [NT_W-1:0]     nearest_t_reg;
    logic [TAG_BITS-1:0] nearest_tag_reg;
    logic                have_hit_reg;
    logic signed [P_W-1:0] px_reg, py_reg;
    logic                out_valid_reg, out_found_reg;
    logic [15:0]         out_tag_reg;
    logic [16:0]         out_t_reg;
    logic signed [31:0]  out_x_reg, out_y_reg;

    logic signed [NUM_W-1:0] dx, dy, div_num, div_den;
    logic div_done;
    logic signed [Q_W-1:0] div_q;
    logic signed [Q_W-1:0] t1x, t2x, tlo_x, thi_x, t1y, t2y, tlo_y, thi_y;
    logic pass_x, pass_y, better;
    logic signed [P_W:0] rx, ry;
    logic signed [31:0] sat_x, sat_y;
    logic out_free;

    assign dx = {cfg.end_x[31], cfg.end_x} - {cfg.start_x[31], cfg.start_x};
    assign dy = {cfg.end_y[31], cfg.end_y} - {cfg.start_y[31], cfg.start_y};

    always_comb
    begin
        case (k_reg)
            2'd0:    begin div_num = ent_reg.nlx; div_den = dx; end
            2'd1:    begin div_num = ent_reg.nhx; div_den = dx; end
            2'd2:    begin div_num = ent_reg.nly; div_den = dy; end
            default: begin div_num = ent_reg.nhy; div_den = dy; end
        endcase
    end

    saanh_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_START),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    // Interval narrowing on x, then on y; a still axis needs start inside the span.
    always_comb
    begin
        t1x = (q_reg[0] < q_reg[1]) ? q_reg[0] : q_reg[1];
        t2x = (q_reg[0] < q_reg[1]) ? q_reg[1] : q_reg[0];
        if (dx == '0)
        begin
            tlo_x  = '0;
            thi_x  = T_ONE_Q;
            pass_x = (ent_reg.nlx <= 0) && (ent_reg.nhx >= 0);
        end
        else
        begin
            tlo_x  = (t1x > 0) ? t1x : '0;
            thi_x  = (t2x < T_ONE_Q) ? t2x : T_ONE_Q;
            pass_x = tlo_x <= thi_x;
        end
        t1y = (q_reg[2] < q_reg[3]) ? q_reg[2] : q_reg[3];
        t2y = (q_reg[2] < q_reg[3]) ? q_reg[3] : q_reg[2];
        if (dy == '0)
        begin
            tlo_y  = tlo_x;
            thi_y  = thi_x;
            pass_y = (ent_reg.nly <= 0) && (ent_reg.nhy >= 0);
        end
        else
        begin
            tlo_y  = (t1y > tlo_x) ? t1y : tlo_x;
            thi_y  = (t2y < thi_x) ? t2y : thi_x;
            pass_y = tlo_y <= thi_y;
        end
        better = pass_x && pass_y && (tlo_y < $signed({1'b0, nearest_t_reg}));
    end

    always_comb
    begin
        rx = $signed({{(P_W-31){cfg.start_x[31]}}, cfg.start_x})
             + ($signed({px_reg[P_W-1], px_reg}) >>> T_FRAC_BITS);
        ry = $signed({{(P_W-31){cfg.start_y[31]}}, cfg.start_y})
             + ($signed({py_reg[P_W-1], py_reg}) >>> T_FRAC_BITS);
        sat_x = (rx > PT_MAX) ? 32'sh7fffffff : (rx < PT_MIN) ? 32'sh80000000 : 32'(rx);
        sat_y = (ry > PT_MAX) ? 32'sh7fffffff : (ry < PT_MIN) ? 32'sh80000000 : 32'(ry);
    end

    assign out_free = !out_valid_reg || hit.ready;
    assign pop = (state_reg == S_IDLE) && head_valid;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (head_valid) state_next = head.skip ? S_FIN : S_START;
            S_START: state_next = S_DIV;
            S_DIV:   if (div_done) state_next = (k_reg == 2'd3) ? S_EVAL : S_START;
            S_EVAL:  state_next = S_FIN;
            S_FIN:   state_next = ent_reg.last ? S_MUL : S_IDLE;
            S_MUL:   state_next = S_OUT;
            S_OUT:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ent_reg <= head;
        end
        if (state_reg == S_DIV && div_done)
        begin
            q_reg[k_reg] <= div_q;
        end
        if (state_reg == S_MUL)
        begin
            px_reg <= dx * $signed({1'b0, nearest_t_reg});
            py_reg <= dy * $signed({1'b0, nearest_t_reg});
        end
        if (state_reg == S_OUT && out_free)
        begin
            out_found_reg <= have_hit_reg;
            out_tag_reg   <= have_hit_reg ? 16'(nearest_tag_reg) : '0;
            out_t_reg     <= have_hit_reg ? 17'(nearest_t_reg) : '0;
            out_x_reg     <= have_hit_reg ? sat_x : '0;
            out_y_reg     <= have_hit_reg ? sat_y : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            k_reg           <= '0;
            nearest_t_reg   <= T_SAT_NT;
            nearest_tag_reg <= '0;
            have_hit_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                k_reg <= '0;
            end
            else if (state_reg == S_DIV && div_done)
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (state_reg == S_EVAL && better)
            begin
                nearest_t_reg   <= NT_W'(tlo_y);
                nearest_tag_reg <= ent_reg.tag;
                have_hit_reg    <= 1'b1;
            end
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg   <= 1'b1;
                nearest_t_reg   <= T_SAT_NT;
                nearest_tag_reg <= '0;
                have_hit_reg    <= 1'b0;
            end
            else if (hit.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign hit.valid       = out_valid_reg;
    assign hit.hit_found   = out_found_reg;
    assign hit.hit_tag     = out_tag_reg;
    assign hit.hit_t       = out_t_reg;
    assign hit.hit_point_x = out_x_reg;
    assign hit.hit_point_y = out_y_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        !have_hit_reg |-> (nearest_t_reg == T_SAT_NT && nearest_tag_reg == '0))
        else $error("search state dirty without a hit");
    assert property (@(posedge clk) disable iff (!rst_n)
        have_hit_reg |-> nearest_t_reg <= NT_W'(T_ONE_Q))
        else $error("recorded hit time above one");

endmodule
`default_nettype wire

>>> sv/segment_aabb_nearest_hit_top.sv
// Top level of the segment versus box nearest-hit block.
// The segment is set through the write port (cfg_we, cfg_index, cfg_data):
// index 0..3 are start x, start y, end x, end y in signed Q16.16, index 4 is
// the target layer mask. Other indexes are ignored. Write only while idle.
// Boxes arrive as requests on the box channel; one is accepted when valid and
// ready are both high. A box that is inactive or whose layers miss the mask is
// dropped without a division. Any other box runs four slab divisions through one
// shared radix-2 divider, one after another; that divider sets the throughput.
// A two-entry queue lets the front take boxes while the back is busy.
// The box flagged last produces one request on the hit channel, registered as
// the back end leaves its FIN, MUL and OUT states, carrying found flag, tag,
// entry t (Q1.16) and hit point.
// The result sits in an output register; while the receiver stalls, the back
// end still works through queued boxes and only waits when the next result
// is due. After each result the search state is cleared.
// Reset clears the queue, the search state and the configuration registers, with the mask
// set to all ones.
`default_nettype none
module segment_aabb_nearest_hit_top
    import saanh_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    box_if.sink                       box,
    hit_if.source                     hit
);

    cfg_t     cfg_reg;
    q_entry_t head;
    logic     head_valid;
    logic     pop;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_x <= '0;
            cfg_reg.start_y <= '0;
            cfg_reg.end_x   <= '0;
            cfg_reg.end_y   <= '0;
            cfg_reg.mask    <= '1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_X: cfg_reg.start_x <= cfg_data;
                REG_START_Y: cfg_reg.start_y <= cfg_data;
                REG_END_X:   cfg_reg.end_x   <= cfg_data;
                REG_END_Y:   cfg_reg.end_y   <= cfg_data;
                REG_MASK:    cfg_reg.mask    <= cfg_data;
                default:     ;
            endcase
        end
    end

    saanh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .box        (box),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    saanh_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .hit        (hit)
    );

endmodule
`default_nettype wire

>>> dv/saanh_tb_if.sv
// Testbench-wide constants used by the stimulus.
`timescale 1ns / 100ps
`default_nettype none
package saanh_tb_pkg;
    import saanh_pkg::*;

    // An index past the register list; writes to it must leave the block alone.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam longint CYCLE_LIMIT = 2000000;

endpackage
`default_nettype wire

>>> dv/saanh_checker.sv
// Checker that predicts the nearest hit of each cast and compares results.
`timescale 1ns / 100ps
`default_nettype none
module saanh_checker
    import saanh_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    box_if                            box,
    hit_if                            hit,
    output int                        fail_count,
    output int                        pending,
    output int                        casts_seen
);
    typedef struct {
        logic        found;
        logic [15:0] tag;
        logic [16:0] t;
        logic [31:0] px;
        logic [31:0] py;
    } hit_res_t;

    localparam longint T_ONE = 64'sd1 << T_FRAC_BITS;
    localparam longint T_SAT = 64'sd2 << T_FRAC_BITS;

    logic [31:0] sx_r, sy_r, ex_r, ey_r, mask_r;
    longint      best_t;
    logic [15:0] best_tag;
    logic        best_valid;
    hit_res_t    expected_hits[$];

    function automatic longint clamp_quot(longint num, longint den);
        longint q;
        q = (num * T_ONE) / den;
        if (q > T_SAT) q = T_SAT;
        if (q < -T_SAT) q = -T_SAT;
        return q;
    endfunction

    // One slab axis; narrows the entry/exit window and reports overlap.
    function automatic bit slab_pass(longint s, longint d, longint lo, longint hi,
                                     ref longint tlo, ref longint thi);
        longint t1, t2, tmp;
        if (d == 0) return (s >= lo) && (s <= hi);
        t1 = clamp_quot(lo - s, d);
        t2 = clamp_quot(hi - s, d);
        if (t1 > t2) begin tmp = t1; t1 = t2; t2 = tmp; end
        if (t1 > tlo) tlo = t1;
        if (t2 < thi) thi = t2;
        return tlo <= thi;
    endfunction

    // Start plus floor(d * t / 2^F), saturated to 32 bits.
    function automatic logic [31:0] point_on_segment(longint s, longint d, longint t);
        longint p, f, r;
        p = d * t;
        if (p >= 0) f = p / T_ONE;
        else f = -((-p + T_ONE - 1) / T_ONE);
        r = s + f;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    task automatic cast_box();
        longint sx, sy, dx, dy, tlo, thi;
        hit_res_t r;
        sx = longint'($signed(sx_r));
        sy = longint'($signed(sy_r));
        dx = longint'($signed(ex_r)) - sx;
        dy = longint'($signed(ey_r)) - sy;
        tlo = 0;
        thi = T_ONE;
        if (box.box_active && (box.box_layer & mask_r) != 0) begin
            if (slab_pass(sx, dx, longint'(box.box_left), longint'(box.box_right), tlo, thi)
                && slab_pass(sy, dy, longint'(box.box_top), longint'(box.box_bottom),
                             tlo, thi)
                && tlo < best_t) begin
                best_t = tlo;
                best_tag = box.box_tag;
                best_valid = 1'b1;
            end
        end
        if (box.last_box) begin
            if (best_valid) begin
                r.found = 1'b1;
                r.tag = best_tag;
                r.t = best_t[16:0];
                r.px = point_on_segment(sx, dx, best_t);
                r.py = point_on_segment(sy, dy, best_t);
            end else begin
                r = '{1'b0, 16'd0, 17'd0, 32'd0, 32'd0};
            end
            expected_hits = {expected_hits, r};
            best_t = T_SAT;
            best_tag = '0;
            best_valid = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        hit_res_t w;
        if (!rst_n)
        begin
            sx_r = '0; sy_r = '0; ex_r = '0; ey_r = '0; mask_r = '1;
            best_t = T_SAT; best_tag = '0; best_valid = 1'b0;
            fail_count = 0;
            casts_seen = 0;
            expected_hits.delete();
            pending = 0;
        end
        else
        begin
            if (hit.valid && hit.ready)
            begin
                if (expected_hits.size() == 0)
                    report_mismatch("unexpected result", 1, 0);
                else
                begin
                    w = expected_hits.pop_front();
                    casts_seen++;
                    if (hit.hit_found !== w.found) report_mismatch("hit_found", hit.hit_found, w.found);
                    if (hit.hit_tag !== w.tag) report_mismatch("hit_tag", hit.hit_tag, w.tag);
                    if (hit.hit_t !== w.t) report_mismatch("hit_t", hit.hit_t, w.t);
                    if (hit.hit_point_x !== w.px)
                        report_mismatch("hit_point_x", hit.hit_point_x, w.px);
                    if (hit.hit_point_y !== w.py)
                        report_mismatch("hit_point_y", hit.hit_point_y, w.py);
                end
            end
            if (box.valid && box.ready)
                cast_box();
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_START_X: sx_r = cfg_data;
                    REG_START_Y: sy_r = cfg_data;
                    REG_END_X:   ex_r = cfg_data;
                    REG_END_Y:   ey_r = cfg_data;
                    REG_MASK:    mask_r = cfg_data;
                    default: ;
                endcase
            end
            pending = expected_hits.size();
        end
    end
endmodule
`default_nettype wire

>>> dv/testbench.sv
// Testbench top: drives segments and boxes into the nearest-hit block.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import saanh_pkg::*;
    import saanh_tb_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_START_X;
    logic [31:0]          cfg_data = '0;
    int                   fail_count, pending, casts_seen;
    int                   boxes_sent = 0;
    longint               cycle = 0;

    // Idling knobs: when calm is set neither side idles.
    bit calm = 1'b0;
    bit hold_off = 1'b0;

    box_if box ();
    hit_if hit ();

    segment_aabb_nearest_hit_top u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .box(box), .hit(hit)
    );

    saanh_checker u_checker (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .box(box), .hit(hit), .fail_count(fail_count),
        .pending(pending), .casts_seen(casts_seen)
    );

    always #5 clk = ~clk;

    // Even the worst-case run stays far below this cycle limit.
    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // The receiver stalls about a third of the time, unless held off or calm.
    always @(posedge clk)
    begin
        if (!rst_n) hit.ready <= 1'b0;
        else if (hold_off) hit.ready <= 1'b0;
        else hit.ready <= calm ? 1'b1 : ($urandom_range(99) >= 33);
    end

    // Drives one register write for a cycle; the caller drops the enable.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // Stops offering boxes and waits until every cast has reported.
    task automatic drain();
        box.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Waits until every cast has reported, then lets the back end drain.
    task automatic settle();
        drain();
        repeat (200) @(posedge clk);
    endtask

    task automatic set_segment(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex,
                               logic [31:0] ey, logic [31:0] mask);
        settle();
        write_reg(REG_START_X, sx);
        write_reg(REG_START_Y, sy);
        write_reg(REG_END_X, ex);
        write_reg(REG_END_Y, ey);
        write_reg(REG_MASK, mask);
        // Index beyond the register list must be ignored.
        write_reg(REG_UNUSED, $urandom);
        cfg_we <= 1'b0;
    endtask

    // Offers one request, with random idle cycles ahead of it, and waits for acceptance.
    // Valid stays high afterwards so that requests can follow back to back.
    task automatic send_box(logic act, logic [31:0] layer, logic [31:0] l, logic [31:0] r,
                            logic [31:0] t, logic [31:0] b, logic [15:0] tag, logic last);
        while (!calm && $urandom_range(99) < 33)
        begin
            box.valid <= 1'b0;
            @(posedge clk);
        end
        box.valid <= 1'b1;
        box.box_active <= act;
        box.box_layer <= layer;
        box.box_left <= l;
        box.box_right <= r;
        box.box_top <= t;
        box.box_bottom <= b;
        box.box_tag <= tag;
        box.last_box <= last;
        @(posedge clk);
        while (!box.ready) @(posedge clk);
        boxes_sent++;
    endtask

    // A random coordinate: mostly within +-20.0 of the origin, sometimes extreme.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'h7FFFFFFF;
            2: return 32'h80000000;
            default: return $signed($urandom_range(40 << 16)) - (20 << 16);
        endcase
    endfunction

    task automatic random_box(logic last);
        logic [31:0] l, r, t, b;
        l = rand_coord(); r = rand_coord(); t = rand_coord(); b = rand_coord();
        // Mostly well-formed spans, some left inverted.
        if ($urandom_range(9) != 0 && $signed(l) > $signed(r)) begin l ^= r; r ^= l; l ^= r; end
        if ($urandom_range(9) != 0 && $signed(t) > $signed(b)) begin t ^= b; b ^= t; t ^= b; end
        send_box($urandom_range(9) != 0, ($urandom_range(4) == 0) ? $urandom : '1,
                 l, r, t, b, 16'($urandom), last);
    endtask

    task automatic random_segment();
        logic [31:0] sx, sy, ex, ey, m;
        sx = rand_coord(); sy = rand_coord(); ex = rand_coord(); ey = rand_coord();
        case ($urandom_range(5))
            0: ex = sx;
            1: ey = sy;
            default: ;
        endcase
        m = ($urandom_range(3) == 0) ? $urandom : '1;
        set_segment(sx, sy, ex, ey, m);
    endtask

    initial
    begin
        int n;
        box.valid <= 1'b0; box.box_active <= 1'b0; box.box_layer <= '0;
        box.box_left <= '0; box.box_right <= '0; box.box_top <= '0; box.box_bottom <= '0;
        box.box_tag <= '0; box.last_box <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: diagonal segment across the origin against hand-picked boxes.
        set_segment(-(10 << 16), -(10 << 16), 10 << 16, 10 << 16, '1);
        send_box(1'b1, 32'd1, -(1 << 16), 1 << 16, -(1 << 16), 1 << 16, 16'h0001, 1'b0);
        // Equal entry t: the earlier box must win.
        send_box(1'b1, 32'd1, -(1 << 16), 1 << 16, -(1 << 16), 1 << 16, 16'h0002, 1'b0);
        // Inactive but nearer box is ignored.
        send_box(1'b0, 32'd1, -(9 << 16), 9 << 16, -(9 << 16), 9 << 16, 16'h0003, 1'b0);
        send_box(1'b1, 32'd0, -(9 << 16), 9 << 16, -(9 << 16), 9 << 16, 16'h0004, 1'b1);
        // Nearer box wins; an inverted box misses; masked last box still reports.
        send_box(1'b1, 32'd1, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                 16'hFFFF, 1'b0);
        send_box(1'b1, 32'd1, 1 << 16, -(1 << 16), 1 << 16, -(1 << 16), 16'h0005, 1'b0);
        send_box(1'b1, 32'h0, 0, 0, 0, 0, 16'h0006, 1'b1);
        // Nothing hit at all.
        send_box(1'b1, 32'd1, 20 << 16, 30 << 16, 20 << 16, 30 << 16, 16'h0007, 1'b1);

        // No movement on x; start inside and outside the x span.
        set_segment(3 << 16, 32'h80000000, 3 << 16, 32'h7FFFFFFF, 32'h0000_00F0);
        send_box(1'b1, 32'h10, 3 << 16, 4 << 16, 0, 5 << 16, 16'h0010, 1'b0);
        send_box(1'b1, 32'h10, 4 << 16, 5 << 16, -(5 << 16), 0, 16'h0011, 1'b0);
        send_box(1'b1, 32'h01, 0, 5 << 16, -(5 << 16), 0, 16'h0012, 1'b1);
        // Zero-length segment sitting in a box.
        set_segment(0, 0, 0, 0, 32'h8000_0000);
        send_box(1'b1, 32'h8000_0000, 0, 0, 0, 0, 16'h0013, 1'b1);
        // Extreme segment, saturating quotients.
        set_segment(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, '1);
        send_box(1'b1, '1, -1, 1, -1, 1, 16'hAAAA, 1'b0);
        send_box(1'b1, '1, 32'h7FFFFFF0, 32'h7FFFFFFF, 32'h80000000, 32'h8000000F,
                 16'h5555, 1'b1);

        // Random casts: short lists of boxes, a new segment every few casts.
        while (boxes_sent < 1700)
        begin
            if ($urandom_range(3) == 0) random_segment();
            // A calm stretch with no idling in the middle of the run.
            calm = (boxes_sent > 700 && boxes_sent < 900);
            // Long receiver hold-off while the sender keeps offering.
            if (boxes_sent > 400 && boxes_sent < 420 && !hold_off)
            begin
                hold_off = 1'b1;
                fork
                    begin
                        repeat (3000) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            // Sender pause until every result is in.
            if (boxes_sent > 1200 && boxes_sent < 1210)
                drain();
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) random_box(i == n - 1);
        end
        calm = 1'b0;

        settle();
        $display("Sent %0d boxes; %0d cast results compared, covering still axes, masks,",
                 boxes_sent, casts_seen);
        $display("inverted spans, saturated quotients and stalls on both sides.");
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
